/* rtl/pcdf_pkg.sv */
package pcdf_pkg;

  // Width of the timer stamps that take part in the period arithmetic.
  localparam int unsigned STAMP_BITS = 16;
  localparam int unsigned CaptureW   = 16;
  localparam int unsigned PeriodW    = STAMP_BITS + 1;
  localparam int unsigned DutyW      = 7;
  localparam int unsigned FreqW      = 32;
  localparam int unsigned ProdW      = STAMP_BITS + DutyW;
  localparam int unsigned DivW       = (ProdW > FreqW) ? ProdW : FreqW;
  localparam int unsigned CntW       = $clog2(DivW + 1);

  localparam int unsigned PercentScale = 100;
  localparam int unsigned TickRateReset = 250000;

  // The duty quotient never exceeds 100, so seven quotient bits suffice.
  localparam int unsigned DutySteps = DutyW;
  localparam int unsigned FreqSteps = FreqW;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [PeriodW-1:0]    period_t;
  typedef logic [ProdW-1:0]      prod_t;
  typedef logic [DivW-1:0]       div_t;
  typedef logic [CntW-1:0]       cnt_t;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_EDGE  = 1'b1;

  typedef struct packed {
    logic    start;
    period_t divisor;
    period_t rem_init;
    div_t    feed;
    cnt_t    steps;
  } div_req_t;

  typedef struct packed {
    logic done;
    div_t quot;
  } div_rsp_t;

endpackage

/* rtl/pwm_capture_duty_frequency.sv */
// Channel  | Handshake                        | Payload
// ---------+----------------------------------+-------------------------------------------
// input    | in_valid_i / in_stall_o          | req_type_i, edge_rising_i, capture_time_i
// result   | out_valid_o / out_stall_i        | duty_percent_o, frequency_hz_o, period_zero_o
// config   | cfg_valid_i / cfg_ready_o        | cfg_data_i (tick rate)
//
// Start requests and edges that do not complete a measurement are taken without a stall.
// A closing rise stalls the input through two divider loads, 7 + 32 restoring steps, the
// pickup of each quotient and the fill of the output register. A zero period skips the divider
// and stalls the input until the output register is free. Reset (rst_ni low, asynchronous)
// leaves the block idle with the tick rate at 250000. Requests keep flowing while a result
// waits; the input stalls only while a calculation runs or its result cannot reach the output.
module pwm_capture_duty_frequency import pcdf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic                edge_rising_i,
  input  logic [CaptureW-1:0] capture_time_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DutyW-1:0]    duty_percent_o,
  output logic [FreqW-1:0]    frequency_hz_o,
  output logic                period_zero_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [FreqW-1:0]    cfg_data_i
);

  // Capture phases: waiting for the first rise, the fall, the second rise, or idle.
  typedef enum logic [1:0] {
    PH_FIRST_RISE  = 2'd0,
    PH_FALL        = 2'd1,
    PH_SECOND_RISE = 2'd2,
    PH_IDLE        = 2'd3
  } phase_e;

  // Sequencer states around the shared divider.
  typedef enum logic [1:0] {
    S_READY,
    S_DUTY,
    S_FREQ,
    S_HOLD
  } state_e;

  state_e   state_q;
  phase_e   phase_q;
  stamp_t   rise_q;
  stamp_t   fall_q;
  period_t  period_q;
  logic [FreqW-1:0] tick_rate_q;
  div_req_t div_req_q;
  div_rsp_t div_rsp;

  // Result waiting for the output register.
  logic [DutyW-1:0] res_duty_q;
  logic [FreqW-1:0] res_freq_q;
  logic             res_zero_q;

  // Output register.
  logic             out_valid_q;
  logic [DutyW-1:0] out_duty_q;
  logic [FreqW-1:0] out_freq_q;
  logic             out_zero_q;

  logic    in_accept;
  logic    closes;
  stamp_t  stamp;
  stamp_t  high_t;
  stamp_t  low_t;
  period_t period;
  prod_t   high_scaled;
  logic    out_free;
  logic    div_start;
  logic    out_load;

  assign in_stall_o  = (state_q != S_READY);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // The stamp is reduced to the stamp width, and the high and low times wrap at that width.
  assign stamp       = stamp_t'(capture_time_i);
  assign high_t      = fall_q - rise_q;
  assign low_t       = stamp - fall_q;
  assign period      = {1'b0, high_t} + {1'b0, low_t};
  assign high_scaled = prod_t'(high_t) * prod_t'(PercentScale);

  // An edge event completes a measurement when it is the rise that the last phase awaits.
  assign closes = (req_type_i == REQ_EDGE) && (phase_q == PH_SECOND_RISE) && edge_rising_i;

  // The output register can take a new result when it is empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  // A division starts on a closing edge with a non-zero period, and again once the duty
  // quotient is in; a finished result moves to the output register when that is free.
  assign div_start = (state_q == S_READY && in_accept && closes && period != '0) ||
                     (state_q == S_DUTY && div_rsp.done);
  assign out_load  = (state_q == S_HOLD) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= FreqW'(TickRateReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      tick_rate_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_READY;
      phase_q         <= PH_IDLE;
      rise_q          <= '0;
      fall_q          <= '0;
      out_valid_q     <= 1'b0;
      div_req_q.start <= 1'b0;
    end else begin
      div_req_q.start <= div_start;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_READY: begin
          if (in_accept) begin
            if (req_type_i == REQ_START) begin
              phase_q <= PH_FIRST_RISE;
            end else begin
              case (phase_q)
                PH_FIRST_RISE: begin
                  if (edge_rising_i) begin
                    rise_q  <= stamp;
                    phase_q <= PH_FALL;
                  end
                end
                PH_FALL: begin
                  if (!edge_rising_i) begin
                    fall_q  <= stamp;
                    phase_q <= PH_SECOND_RISE;
                  end
                end
                PH_SECOND_RISE: begin
                  if (closes) begin
                    phase_q <= PH_IDLE;
                  end
                end
                default: begin
                end
              endcase
              if (closes) begin
                if (period == '0) begin
                  res_duty_q <= '0;
                  res_freq_q <= '0;
                  res_zero_q <= 1'b1;
                  state_q    <= S_HOLD;
                end else begin
                  // High time never exceeds the period, so the scaled high time shifted
                  // down by the seven quotient bits is already below the divisor.
                  period_q           <= period;
                  res_zero_q         <= 1'b0;
                  div_req_q.divisor  <= period;
                  div_req_q.rem_init <= period_t'(high_scaled >> DutySteps);
                  div_req_q.feed     <= div_t'(high_scaled[DutySteps-1:0]) << (DivW - DutySteps);
                  div_req_q.steps    <= cnt_t'(DutySteps);
                  state_q            <= S_DUTY;
                end
              end
            end
          end
        end
        S_DUTY: begin
          if (div_rsp.done) begin
            res_duty_q         <= div_rsp.quot[DutyW-1:0];
            div_req_q.divisor  <= period_q;
            div_req_q.rem_init <= '0;
            div_req_q.feed     <= div_t'(tick_rate_q) << (DivW - FreqSteps);
            div_req_q.steps    <= cnt_t'(FreqSteps);
            state_q            <= S_FREQ;
          end
        end
        S_FREQ: begin
          if (div_rsp.done) begin
            res_freq_q <= div_rsp.quot[FreqW-1:0];
            state_q    <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_duty_q  <= res_duty_q;
            out_freq_q  <= res_freq_q;
            out_zero_q  <= res_zero_q;
            state_q     <= S_READY;
          end
        end
        default: begin
          state_q <= S_READY;
        end
      endcase
    end
  end

  pcdf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign duty_percent_o = out_duty_q;
  assign frequency_hz_o = out_freq_q;
  assign period_zero_o  = out_zero_q;

`ifndef ASSERT_OFF
  a_duty_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_duty_q <= DutyW'(PercentScale))
    else $error("duty above one hundred percent");

  a_zero_period_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_zero_q |-> out_duty_q == '0 && out_freq_q == '0)
    else $error("zero period result carries non-zero values");

  a_done_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DUTY || state_q == S_FREQ)
    else $error("divider finished outside a division state");

  a_closing_edge_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && closes |=> in_stall_o)
    else $error("input not stalled after a closing edge");
`endif

endmodule

/* rtl/pcdf_div.sv */
module pcdf_div import pcdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic    busy_q, busy_d;
  logic    done_q, done_d;
  cnt_t    cnt_q, cnt_d;
  period_t rem_q, rem_d;
  period_t dvs_q, dvs_d;
  div_t    acc_q, acc_d;

  logic [PeriodW:0]   partial;
  logic [PeriodW+1:0] trial;
  logic               fits;

  // One restoring step: bring down the next dividend bit and try the divisor.
  assign partial = {rem_q, acc_q[DivW-1]};
  assign trial   = {1'b0, partial} - {2'b00, dvs_q};
  assign fits    = ~trial[PeriodW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      dvs_d  = req_i.divisor;
      acc_d  = req_i.feed;
    end else if (busy_q) begin
      rem_d = fits ? trial[PeriodW-1:0] : partial[PeriodW-1:0];
      acc_d = {acc_q[DivW-2:0], fits};
      cnt_d = cnt_q - cnt_t'(1);
      if (cnt_q == cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

`ifndef ASSERT_OFF
  a_busy_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with no steps left");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider signals done while still busy");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("partial remainder not below divisor");
`endif

endmodule
